@@ rtl/assert_macros.svh @@
// assert_macros.svh: concurrent assertion macros shared by the RTL.
// No dependencies; include after the module's port list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/stk_pkg.sv @@
// stk_pkg: types, constants and helpers for the LIFO stack with search.
// No dependencies; used by every module of the block.
package stk_pkg;

    // Storage geometry
    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Operation codes
    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_POP_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_PUSH_FULL    = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND    = 3'd3;
    localparam logic [2:0] STAT_SEARCH_EMPTY = 3'd4;

    typedef logic [WORD_BITS-1:0] t_word;

    // Request and response payloads
    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] position;
        logic [6:0] fill_count;
    } t_rsp;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic compare;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic go_scan;
        logic match;
        logic last;
    } t_dp_stat;

    // Sign-extend the 32-bit request word, keep the low WORD_BITS bits
    function automatic t_word to_word(input logic signed [31:0] v);
        logic [63:0] ext;
        ext = {{32{v[31]}}, v};
        return ext[WORD_BITS-1:0];
    endfunction

endpackage

@@ rtl/stk_ctrl.sv @@
// stk_ctrl: controller FSM for the stack; sequences the search scan.
// Depends on stk_pkg.
module stk_ctrl
    import stk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && i_stat.go_scan) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.match || i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = start;
            end
            ST_SCAN: begin
                o_cmd.compare = 1'b1;
                busy          = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/stk_dp.sv @@
// stk_dp: stack datapath: entry memory, fill count, scan index, compare
// and response register. Depends on stk_pkg and assert_macros.svh.
module stk_dp
    import stk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_rsp     o_rsp,
    output logic     o_done
);

    `include "assert_macros.svh"

    t_word             mem [DEPTH];
    t_word             r_rd_data;
    t_word             r_key;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] n_rd_addr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic              r_valid;
    logic              n_valid;
    t_word             req_word;
    logic              full;
    logic              empty;
    logic              match;
    logic              last;
    logic              do_push;

    assign req_word = to_word(i_req.value);
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign match    = (r_rd_data == r_key);
    assign last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign do_push  = i_cmd.accept && (i_req.func == FUNC_PUSH) && !full;

    assign o_stat.go_scan = (i_req.func == FUNC_SEARCH) && !empty;
    assign o_stat.match   = match;
    assign o_stat.last    = last;

    // Read address: bottom entry on a new request, else the next entry
    assign n_rd_addr = i_cmd.accept ? '0 : r_idx + ADDR_W'(1);

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_count[ADDR_W-1:0]] <= req_word;
        end
        r_rd_data <= mem[n_rd_addr];
    end

    // Scan index and search key
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= '0;
            r_key <= req_word;
        end else if (i_cmd.compare) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // Operation decode and response
    always_comb begin
        n_count            = r_count;
        n_valid            = 1'b0;
        n_rsp              = r_rsp;
        n_rsp.position     = '0;
        n_rsp.status       = STAT_OK;
        if (i_cmd.accept) begin
            n_valid = 1'b1;
            case (i_req.func)
                FUNC_PUSH: begin
                    if (full) begin
                        n_rsp.status = STAT_PUSH_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                FUNC_POP: begin
                    if (empty) begin
                        n_rsp.status = STAT_POP_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                FUNC_SEARCH: begin
                    if (empty) begin
                        n_rsp.status = STAT_SEARCH_EMPTY;
                    end else begin
                        n_valid = 1'b0;
                    end
                end
                default: n_rsp.status = STAT_OK;
            endcase
            n_rsp.fill_count = 7'(n_count);
        end else if (i_cmd.compare) begin
            n_rsp.fill_count = 7'(r_count);
            if (match) begin
                n_valid        = 1'b1;
                n_rsp.position = 7'(CNT_W'(r_idx) + CNT_W'(1));
            end else if (last) begin
                n_valid      = 1'b1;
                n_rsp.status = STAT_NOT_FOUND;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_valid;

    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(DEPTH), "fill count above depth")
    `ASSERT_CLK(a_scan_in_range, i_clk, i_rst_n, i_cmd.compare |-> (CNT_W'(r_idx) < r_count), "scan index past top of stack")
    `ASSERT_CLK(a_pos_le_fill, i_clk, i_rst_n, (r_valid && r_rsp.position != '0) |-> (r_rsp.position <= r_rsp.fill_count), "match position above fill count")

endmodule

@@ rtl/stack_with_search_core.sv @@
// Push, pop, unused codes and a search of an empty stack: result strobe in the cycle after
// the request is taken. Search: one entry compared per cycle from the bottom while busy is
// high; the result is registered from the compare that finds the first match or the top entry.
// A new request is taken in the cycle a result is shown; results cannot be stalled.
// Synchronous active-low reset empties the stack; entry memory is not cleared.
module stack_with_search_core
    import stk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Controller
    stk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Datapath
    stk_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for stack_with_search_core (push, pop, linear search).
// Depends on stk_pkg for the request/response structs and the operation and status codes.
// Results are predicted at request acceptance and checked in order against the DUT strobe.
module tb;
    import stk_pkg::*;

    // Code outside the defined operations; must answer ok with no change
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CLK_HALF = 4;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // Predicted stack contents and fill count
    t_word stack_mem [DEPTH];
    int    stack_fill;

    t_rsp  expected_rsp_q [$];
    int    mismatch_count;
    int    requests_taken;
    int    results_checked;
    int    status_count [5];
    logic [31:0] value_pool [8];

    stack_with_search_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    // Clock: period 8
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Stack behavior for one accepted request; updates the predicted state
    function automatic t_rsp predict_stack_op(input t_req r);
        t_rsp  rsp;
        t_word w;
        rsp = '0;
        w = t_word'(longint'(r.value));
        case (r.func)
            FUNC_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    rsp.status = STAT_PUSH_FULL;
                end else begin
                    stack_mem[stack_fill] = w;
                    stack_fill++;
                end
            end
            FUNC_POP: begin
                if (stack_fill == 0) rsp.status = STAT_POP_EMPTY;
                else stack_fill--;
            end
            FUNC_SEARCH: begin
                if (stack_fill == 0) begin
                    rsp.status = STAT_SEARCH_EMPTY;
                end else begin
                    rsp.status = STAT_NOT_FOUND;
                    // first match counted from the bottom
                    for (int k = 0; k < stack_fill; k++) begin
                        if (rsp.position == 0 && stack_mem[k] == w) begin
                            rsp.status   = STAT_OK;
                            rsp.position = 7'(k + 1);
                        end
                    end
                end
            end
            default: ;
        endcase
        rsp.fill_count = 7'(stack_fill);
        return rsp;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t, result %0d: %s got %0d expected %0d",
                 $realtime, results_checked, what, got, want);
        mismatch_count++;
    endtask

    // Result checker and request predictor, sampled at the rising edge
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("result with no request pending, status",
                                    o_rsp.status, -1);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", o_rsp.status, want.status);
                    if (o_rsp.position !== want.position)
                        report_mismatch("position", o_rsp.position, want.position);
                    if (o_rsp.fill_count !== want.fill_count)
                        report_mismatch("fill_count", o_rsp.fill_count, want.fill_count);
                    if (want.status <= STAT_SEARCH_EMPTY)
                        status_count[want.status]++;
                end
                results_checked++;
            end
            if (start && !busy) begin
                expected_rsp_q.push_back(predict_stack_op(i_req));
                requests_taken++;
            end
        end
    end

    // Present one request and hold it until taken; start stays high on return
    task automatic send_request(input logic [1:0] f, input logic [31:0] v);
        t_req r;
        r.func  = f;
        r.value = v;
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    // Sender gap; the request bus carries junk meanwhile
    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        i_req <= t_req'({$urandom, $urandom});
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(3) == 0) idle_gap($urandom_range(1, 7));
    endtask

    // Operations on an empty stack, including the unused code
    task automatic test_empty_stack();
        send_request(FUNC_POP, $urandom);
        send_request(FUNC_SEARCH, $urandom);
        idle_gap(2);
        send_request(FUNC_UNUSED, $urandom);
        send_request(FUNC_SEARCH, 32'h0);
    endtask

    // Extreme words, duplicates, hits at several depths, misses
    task automatic test_extreme_words();
        send_request(FUNC_PUSH, 32'h8000_0000);
        send_request(FUNC_PUSH, 32'h7FFF_FFFF);
        send_request(FUNC_PUSH, 32'h0);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF);
        idle_gap(1);
        send_request(FUNC_PUSH, 32'h5555_5555);
        send_request(FUNC_PUSH, 32'hAAAA_AAAA);
        send_request(FUNC_PUSH, 32'h7FFF_FFFF);
        send_request(FUNC_SEARCH, 32'h7FFF_FFFF);
        send_request(FUNC_SEARCH, 32'h8000_0000);
        idle_gap(3);
        send_request(FUNC_SEARCH, 32'hAAAA_AAAA);
        send_request(FUNC_SEARCH, 32'hFFFF_FFFF);
        send_request(FUNC_SEARCH, 32'h1234_5678);
        send_request(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_request(FUNC_POP, 32'h0);
        send_request(FUNC_SEARCH, 32'hAAAA_AAAA);
        send_request(FUNC_SEARCH, 32'h7FFF_FFFF);
        repeat (7) send_request(FUNC_POP, $urandom);
    endtask

    // Fill to capacity, refuse a push, search the top entry, then drain and pop and search the empty stack
    task automatic test_full_stack();
        logic [31:0] top_word;
        top_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            top_word = {16'($urandom_range(16'hFFFF)), 8'($urandom), 8'(k)};
            send_request(FUNC_PUSH, top_word);
            maybe_idle();
        end
        send_request(FUNC_PUSH, $urandom);
        send_request(FUNC_SEARCH, top_word);
        send_request(FUNC_SEARCH, {24'hDEAD_BE, 8'hFF} ^ 32'h0000_00FF);
        send_request(FUNC_UNUSED, $urandom);
        send_request(FUNC_PUSH, top_word);
        for (int k = 0; k < DEPTH; k++) begin
            send_request(FUNC_POP, $urandom);
            maybe_idle();
        end
        send_request(FUNC_POP, $urandom);
        send_request(FUNC_SEARCH, top_word);
    endtask

    // Random mix; push weight drifts per phase so the fill level sweeps its range
    task automatic test_random_traffic(input int items, input bit with_gaps);
        int pick;
        int push_pct;
        logic [1:0] f;
        logic [31:0] v;
        push_pct = 50;
        for (int n = 0; n < items; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(3))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    2: push_pct = 25;
                    default: push_pct = 65;
                endcase
                foreach (value_pool[p]) value_pool[p] = $urandom;
                value_pool[0] = 32'h8000_0000;
                value_pool[1] = 32'h7FFF_FFFF;
            end
            pick = $urandom_range(99);
            if (pick < 3) f = FUNC_UNUSED;
            else if (pick < push_pct) f = FUNC_PUSH;
            else if (pick < push_pct + (100 - push_pct) / 2) f = FUNC_POP;
            else f = FUNC_SEARCH;
            // pool words make searches hit; fresh words mostly miss
            if ($urandom_range(99) < 70) v = value_pool[$urandom_range(7)];
            else v = $urandom;
            send_request(f, v);
            if (with_gaps) maybe_idle();
        end
    endtask

    // Stimulus sequence
    initial begin
        int wait_cycles;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        stack_fill = 0;
        mismatch_count = 0;
        requests_taken = 0;
        results_checked = 0;
        foreach (status_count[s]) status_count[s] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_extreme_words();
        test_full_stack();
        test_random_traffic(900, 1'b1);
        test_random_traffic(150, 1'b0);
        start <= 1'b0;

        // Drain, then allow a full search time for stray results
        wait_cycles = 0;
        while (expected_rsp_q.size() != 0 && wait_cycles < 10 * DEPTH) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (DEPTH + 4) @(posedge i_clk);
        if (expected_rsp_q.size() != 0)
            report_mismatch("results never returned, count", 0, expected_rsp_q.size());

        $display("Run covered %0d requests and %0d results: ok %0d, pop empty %0d,",
                 requests_taken, results_checked, status_count[STAT_OK],
                 status_count[STAT_POP_EMPTY]);
        $display("push full %0d, search miss %0d, search empty %0d; mismatches %0d",
                 status_count[STAT_PUSH_FULL], status_count[STAT_NOT_FOUND],
                 status_count[STAT_SEARCH_EMPTY], mismatch_count);
        if (mismatch_count == 0) begin
            $display("stack_with_search_core test passed");
        end else begin
            $display("stack_with_search_core test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(2 * CLK_HALF * 1_000_000);
        $display("Timeout: %0d results still pending", expected_rsp_q.size());
        $display("stack_with_search_core test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/stk_pkg.sv
rtl/stk_ctrl.sv
rtl/stk_dp.sv
rtl/stack_with_search_core.sv
tb/sv/tb.sv
